[hw/rtl/cd_pkg.sv]
// Shared types, constants and data conversions for the circular deque.
package cd_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int CAP_W   = 5;
	localparam int WORD_W  = 32;
	localparam int CAP_RST = (16 > DEPTH) ? DEPTH : 16;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	// pointer state as seen by the sequencer
	typedef struct packed {
		logic [IDX_W-1:0] head;
		logic [IDX_W-1:0] tail;
		logic [CNT_W-1:0] count;
		logic             empty;
		logic             full;
	} cd_stat_t;

	// outcome of one request: done flag and store write
	typedef struct packed {
		logic              ok;
		logic              we;
		logic [IDX_W-1:0]  addr;
		logic [DATA_W-1:0] data;
	} cd_upd_t;

	function automatic logic [DATA_W-1:0] to_store(input logic signed [WORD_W-1:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		return w[DATA_W-1:0];
	endfunction

	function automatic logic signed [WORD_W-1:0] to_word(input logic [DATA_W-1:0] d);
		logic signed [DATA_W-1:0] s;
		logic signed [63:0]       w;
		s = signed'(d);
		w = 64'(s);
		return w[WORD_W-1:0];
	endfunction

endpackage

[hw/rtl/cd_if.sv]
// Channel interfaces: request, response and capacity write.
interface cd_req_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       op;
	logic signed [cd_pkg::WORD_W-1:0] value;

	modport source (output valid, op, value, input ready);
	modport sink   (input valid, op, value, output ready);
endinterface

interface cd_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             ok;
	logic signed [cd_pkg::WORD_W-1:0] front_value;
	logic signed [cd_pkg::WORD_W-1:0] rear_value;
	logic                             is_empty;
	logic                             is_full;
	logic [cd_pkg::CAP_W-1:0]         count;

	modport source (output valid, ok, front_value, rear_value, is_empty, is_full, count,
		input ready);
	modport sink   (input valid, ok, front_value, rear_value, is_empty, is_full, count,
		output ready);
endinterface

interface cd_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [cd_pkg::CAP_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[hw/rtl/cd_ram.sv]
// Ring store: one write port, two read ports with registered read data.
module cd_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [WIDTH-1:0]  rdata_a,
	output logic [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[hw/rtl/cd_ptr.sv]
// Head, tail, count and capacity registers with the per-request update.
module cd_ptr (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [1:0]                       op,
	input  logic signed [cd_pkg::WORD_W-1:0] value,
	input  logic                             cfg_we,
	input  logic [cd_pkg::CAP_W-1:0]         cfg_data,
	output cd_pkg::cd_stat_t                 stat,
	output cd_pkg::cd_upd_t                  upd
);
	import cd_pkg::*;

	logic [CNT_W-1:0] cap_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	logic [IDX_W-1:0] head_n;
	logic [IDX_W-1:0] tail_n;
	logic [CNT_W-1:0] count_n;
	logic [CNT_W-1:0] cap_w;
	logic             full;
	logic             empty;

	function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p,
		input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] nxt;
		nxt = CNT_W'(p) + 1'b1;
		return (nxt == cap) ? '0 : IDX_W'(nxt);
	endfunction

	function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] p,
		input logic [CNT_W-1:0] cap);
		return (p == '0) ? IDX_W'(cap - 1'b1) : p - 1'b1;
	endfunction

	assign full  = (count_q >= cap_q);
	assign empty = (count_q == '0);

	// saturate the written capacity to 1..DEPTH
	always_comb begin
		if (cfg_data == '0) begin
			cap_w = CNT_W'(1);
		end else if (int'(cfg_data) > DEPTH) begin
			cap_w = CNT_W'(DEPTH);
		end else begin
			cap_w = CNT_W'(cfg_data);
		end
	end

	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		count_n  = count_q;
		upd.ok   = 1'b0;
		upd.we   = 1'b0;
		upd.addr = head_q;
		upd.data = to_store(value);
		case (op_t'(op))
			OP_PUSH_FRONT: begin
				if (!full) begin
					head_n   = ring_dec(head_q, cap_q);
					upd.addr = head_n;
					upd.we   = 1'b1;
					upd.ok   = 1'b1;
					count_n  = count_q + 1'b1;
				end
			end
			OP_PUSH_REAR: begin
				if (!full) begin
					tail_n   = ring_inc(tail_q, cap_q);
					upd.addr = tail_n;
					upd.we   = 1'b1;
					upd.ok   = 1'b1;
					count_n  = count_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (!empty) begin
					head_n  = ring_inc(head_q, cap_q);
					upd.ok  = 1'b1;
					count_n = count_q - 1'b1;
				end
			end
			OP_POP_REAR: begin
				if (!empty) begin
					tail_n  = ring_dec(tail_q, cap_q);
					upd.ok  = 1'b1;
					count_n = count_q - 1'b1;
				end
			end
			default: begin
				upd.ok = 1'b0;
			end
		endcase
		upd.we = upd.we & step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CNT_W'(CAP_RST);
			head_q  <= '0;
			tail_q  <= IDX_W'(CAP_RST - 1);
			count_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= cap_w;
			head_q  <= '0;
			tail_q  <= IDX_W'(cap_w - 1'b1);
			count_q <= '0;
		end else if (step) begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			count_q <= count_n;
		end
	end

	assign stat.head  = head_q;
	assign stat.tail  = tail_q;
	assign stat.count = count_q;
	assign stat.empty = empty;
	assign stat.full  = full;

endmodule

[hw/rtl/circular_deque_top.sv]
// Circular deque top level: request sequencer, ring store and response register.
//
// Channels: req carries op and value, rsp returns one beat per request with
// ok, front_value, rear_value, is_empty, is_full and count; cfg writes the
// capacity (1..16, saturated), which also empties the deque.
// Each request walks three steps: accept (pointer update and store write),
// store read at the new head and tail, and load into the response register.
// A new request is accepted only after the last response is loaded; the ring
// store has registered read data and is read after its write.
// req.ready is high only while the sequencer waits for a request.
// When the receiver stalls, the response register holds its beat; the
// next request may still be accepted and read, and waits in its last step
// until the register frees up.
// Reset empties the deque with capacity 16; store contents are not cleared since
// data read when empty is replaced by all ones. cfg is always ready; the user
// must write it only while no request is in flight; the block does not check.
module circular_deque_top (
	input logic   clk,
	input logic   arst_n,
	cd_req_if.sink   req,
	cd_rsp_if.source rsp,
	cd_cfg_if.sink   cfg
);
	import cd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic              accept;
	logic              load;
	logic              ok_q;
	logic              rsp_valid_q;
	cd_stat_t          stat;
	cd_upd_t           upd;
	logic [DATA_W-1:0] rdata_a;
	logic [DATA_W-1:0] rdata_b;

	logic                      rsp_ok_q;
	logic signed [WORD_W-1:0]  front_q;
	logic signed [WORD_W-1:0]  rear_q;
	logic                      empty_q;
	logic                      full_q;
	logic [CAP_W-1:0]          count_q;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign load      = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	cd_ptr u_ptr (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (accept),
		.op       (req.op),
		.value    (req.value),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.stat     (stat),
		.upd      (upd)
	);

	cd_ram #(
		.DEPTH (DEPTH),
		.WIDTH (DATA_W)
	) u_ram (
		.clk     (clk),
		.we      (upd.we),
		.waddr   (upd.addr),
		.wdata   (upd.data),
		.raddr_a (stat.head),
		.raddr_b (stat.tail),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q <= upd.ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// empty deque reports all ones at both ends
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_ok_q <= ok_q;
			front_q  <= stat.empty ? '1 : to_word(rdata_a);
			rear_q   <= stat.empty ? '1 : to_word(rdata_b);
			empty_q  <= stat.empty;
			full_q   <= stat.full;
			count_q  <= CAP_W'(stat.count);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_ok_q;
	assign rsp.front_value = front_q;
	assign rsp.rear_value  = rear_q;
	assign rsp.is_empty    = empty_q;
	assign rsp.is_full     = full_q;
	assign rsp.count       = count_q;

`ifndef SYNTHESIS
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_READ))
		else $error("accepted request did not move to store read");

	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (state_q == S_DONE))
		else $error("store read did not move to response load");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response beat raised outside the load step");

	a_no_write_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		upd.we |-> (state_q == S_IDLE))
		else $error("store write while a request is in flight");
`endif

endmodule
